@@ rtl/stream_integer_parser_core_defines.svh @@
// ============================================================================
// stream_integer_parser_core_defines : assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ============================================================================
`ifndef STREAM_INTEGER_PARSER_CORE_DEFINES_SVH
`define STREAM_INTEGER_PARSER_CORE_DEFINES_SVH

// same-cycle implication
`define SIP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SIP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sip_pkg.sv @@
// ============================================================================
// sip_pkg : stream integer parser package
// Field widths, character codes, config indexes and the digit decoder.
// ============================================================================
package sip_pkg;

    localparam int CH_W        = 8;
    localparam int RADIX_W     = 5;
    localparam int DIGIT_W     = 4;
    localparam int VALUE_OUT_W = 64;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_X_LO  = 8'h78;
    localparam logic [CH_W-1:0] CH_X_UP  = 8'h58;

    localparam logic [RADIX_W-1:0] RADIX_AUTO = 5'd0;
    localparam logic [RADIX_W-1:0] BASE_OCT   = 5'd8;
    localparam logic [RADIX_W-1:0] BASE_DEC   = 5'd10;
    localparam logic [RADIX_W-1:0] BASE_HEX   = 5'd16;
    localparam logic [RADIX_W-1:0] NO_DIGIT   = 5'd31;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIX       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE = 1'b1;

    typedef enum logic [1:0] {
        PH_SIGN,
        PH_PREFIX,
        PH_AFTER_ZERO,
        PH_DIGITS
    } phase_t;

    // hex digit value; NO_DIGIT is never below any 5-bit base
    function automatic logic [RADIX_W-1:0] hex_digit(input logic [CH_W-1:0] c);
        logic [RADIX_W-1:0] d;
        d = NO_DIGIT;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d = RADIX_W'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            d = RADIX_W'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            d = RADIX_W'(c - 8'h37);
        end
        return d;
    endfunction

endpackage

@@ rtl/sip_stream_if.sv @@
// ============================================================================
// sip_stream_if : character and result channels
// Valid/ready channels carrying one character request and one parse result.
// ============================================================================
interface sip_char_if import sip_pkg::*; ;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;
    logic            end_of_input;

    modport source (output valid, ch, end_of_input, input ready);
    modport sink   (input valid, ch, end_of_input, output ready);
endinterface

interface sip_result_if import sip_pkg::*; ;
    logic                   valid;
    logic                   ready;
    logic [VALUE_OUT_W-1:0] value;
    logic                   status;
    logic                   char_consumed;

    modport source (output valid, value, status, char_consumed, input ready);
    modport sink   (input valid, value, status, char_consumed, output ready);
endinterface

@@ rtl/stream_integer_parser_core.sv @@
// ============================================================================
// stream_integer_parser_core : streaming integer parser
// Parses one integer per number from a character stream, strtoull style.
// ============================================================================
// Usage:
//   chars  : one character request per handshake (ch, end_of_input).
//   result : one result per parsed number (value, status, char_consumed).
//   cfg    : cfg_wr_en/cfg_index/cfg_wdata; index 0 radix, 1 signed_mode.
//            Write only while the parser is idle.
// Steps:
//   Sign, prefix and the 'x' after a leading zero: each taken in S_IDLE.
//   Digit: accept, a shift-add pass of the shared adder for each base bit
//   (S_MUL), then the digit add and overflow check (S_ADD).
//   Ending character: accept, then S_FINISH loads the result register (also
//   for a digit that overflows); next request accepted once it is loaded.
// The ending character is never consumed; the caller presents it again.
// If the result register is still held by a stalled receiver, the parser
// waits before loading it; a new character is accepted while a result waits.
// Reset: radix 10, unsigned mode, parser in sign phase, no result pending.
// ============================================================================
module stream_integer_parser_core
    import sip_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    sip_char_if.sink             chars,
    sip_result_if.source         result,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RADIX_W-1:0]   cfg_wdata
);

    localparam int PROD_W = VALUE_WIDTH + RADIX_W;
    localparam int CNT_W  = $clog2(RADIX_W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_FINISH
    } state_t;

    state_t                   state_reg, state_next;
    phase_t                   phase_reg, phase_next;
    logic [VALUE_WIDTH-1:0]   acc_reg, acc_next;
    logic [RADIX_W-1:0]       base_reg, base_next;
    logic                     negative_reg, negative_next;
    logic [RADIX_W-1:0]       radix_reg, radix_next;
    logic                     signed_mode_reg, signed_mode_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [DIGIT_W-1:0]       digit_reg, digit_next;
    logic                     err_reg, err_next;
    logic                     out_valid_reg, out_valid_next;
    logic [VALUE_OUT_W-1:0]   out_value_reg, out_value_next;
    logic                     out_status_reg, out_status_next;

    logic                     accept;
    logic                     eoi;
    logic [CH_W-1:0]          c;
    logic [RADIX_W-1:0]       dig;
    logic                     step_digit;
    logic                     step_finish;
    logic [RADIX_W-1:0]       step_base;
    phase_t                   step_phase;
    logic                     step_negative;
    logic [PROD_W-1:0]        add_b;
    logic [PROD_W-1:0]        sum;
    logic [VALUE_WIDTH-1:0]   half;
    logic [VALUE_WIDTH-1:0]   fin_value;
    logic                     fin_err;

    assign accept = chars.valid && chars.ready;
    assign eoi    = chars.end_of_input;
    assign c      = chars.ch;
    assign dig    = hex_digit(c);
    assign half   = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    assign chars.ready          = (state_reg == S_IDLE);
    assign result.valid         = out_valid_reg;
    assign result.value         = out_value_reg;
    assign result.status        = out_status_reg;
    assign result.char_consumed = 1'b0;

    // per-character phase decode
    always_comb
    begin
        step_digit    = 1'b0;
        step_finish   = 1'b0;
        step_base     = base_reg;
        step_phase    = phase_reg;
        step_negative = negative_reg;
        case (phase_reg)
            PH_SIGN, PH_PREFIX:
            begin
                if (phase_reg == PH_SIGN && signed_mode_reg && !eoi
                    && (c == CH_MINUS || c == CH_PLUS))
                begin
                    step_negative = (c == CH_MINUS);
                    step_phase    = PH_PREFIX;
                end
                else if (eoi)
                begin
                    step_finish = 1'b1;
                end
                else if (radix_reg == RADIX_AUTO)
                begin
                    if (c == CH_ZERO)
                    begin
                        step_base  = BASE_OCT;
                        step_phase = PH_AFTER_ZERO;
                    end
                    else
                    begin
                        step_base  = BASE_DEC;
                        step_digit = 1'b1;
                    end
                end
                else if (radix_reg == BASE_HEX)
                begin
                    step_base = BASE_HEX;
                    if (c == CH_ZERO)
                    begin
                        step_phase = PH_AFTER_ZERO;
                    end
                    else
                    begin
                        step_digit = 1'b1;
                    end
                end
                else
                begin
                    step_base  = radix_reg;
                    step_digit = 1'b1;
                end
            end
            PH_AFTER_ZERO:
            begin
                if (!eoi && (c == CH_X_LO || c == CH_X_UP))
                begin
                    step_base  = BASE_HEX;
                    step_phase = PH_DIGITS;
                end
                else
                begin
                    step_digit = 1'b1;
                end
            end
            default:
            begin
                step_digit = 1'b1;
            end
        endcase
        if (step_digit)
        begin
            step_phase = PH_DIGITS;
            if (eoi || dig >= step_base)
            begin
                step_finish = 1'b1;
                step_digit  = 1'b0;
            end
        end
    end

    // shared adder: shift-add pass or final digit add
    always_comb
    begin
        if (state_reg == S_MUL)
        begin
            add_b = base_reg[cnt_reg] ? PROD_W'(acc_reg) : '0;
            sum   = {prod_reg[PROD_W-2:0], 1'b0} + add_b;
        end
        else
        begin
            add_b = PROD_W'(digit_reg);
            sum   = prod_reg + add_b;
        end
    end

    // result formation, signed range check
    always_comb
    begin
        fin_value = acc_reg;
        fin_err   = err_reg;
        if (!err_reg && signed_mode_reg)
        begin
            if (negative_reg)
            begin
                if (acc_reg > half)
                begin
                    fin_err = 1'b1;
                end
                else
                begin
                    fin_value = '0 - acc_reg;
                end
            end
            else if (acc_reg >= half)
            begin
                fin_err = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        acc_next         = acc_reg;
        base_next        = base_reg;
        negative_next    = negative_reg;
        radix_next       = radix_reg;
        signed_mode_next = signed_mode_reg;
        prod_next        = prod_reg;
        cnt_next         = cnt_reg;
        digit_next       = digit_reg;
        err_next         = err_reg;
        out_valid_next   = out_valid_reg;
        out_value_next   = out_value_reg;
        out_status_next  = out_status_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_RADIX:       radix_next       = cfg_wdata;
                CFG_SIGNED_MODE: signed_mode_next = cfg_wdata[0];
                default:         ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    phase_next    = step_phase;
                    base_next     = step_base;
                    negative_next = step_negative;
                    if (step_finish)
                    begin
                        err_next   = 1'b0;
                        state_next = S_FINISH;
                    end
                    else if (step_digit)
                    begin
                        prod_next  = '0;
                        cnt_next   = CNT_W'(RADIX_W - 1);
                        digit_next = dig[DIGIT_W-1:0];
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                prod_next = sum;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                if (|sum[PROD_W-1:VALUE_WIDTH])
                begin
                    err_next   = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    acc_next   = sum[VALUE_WIDTH-1:0];
                    state_next = S_IDLE;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = fin_err ? '0 : VALUE_OUT_W'(fin_value);
                    out_status_next = fin_err;
                    phase_next      = PH_SIGN;
                    acc_next        = '0;
                    base_next       = '0;
                    negative_next   = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            phase_reg       <= PH_SIGN;
            acc_reg         <= '0;
            base_reg        <= '0;
            negative_reg    <= 1'b0;
            radix_reg       <= BASE_DEC;
            signed_mode_reg <= 1'b0;
            prod_reg        <= '0;
            cnt_reg         <= '0;
            digit_reg       <= '0;
            err_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_value_reg   <= '0;
            out_status_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            acc_reg         <= acc_next;
            base_reg        <= base_next;
            negative_reg    <= negative_next;
            radix_reg       <= radix_next;
            signed_mode_reg <= signed_mode_next;
            prod_reg        <= prod_next;
            cnt_reg         <= cnt_next;
            digit_reg       <= digit_next;
            err_reg         <= err_next;
            out_valid_reg   <= out_valid_next;
            out_value_reg   <= out_value_next;
            out_status_reg  <= out_status_next;
        end
    end

endmodule

@@ rtl/sip_checker.sv @@
// ============================================================================
// sip_checker : port-level checks for the integer parser
// Watches the request and result channels of stream_integer_parser_core.
// ============================================================================
`include "stream_integer_parser_core_defines.svh"

module sip_checker
    import sip_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [VALUE_OUT_W-1:0] value,
    input logic                   status,
    input logic                   char_consumed
);

    `SIP_ASSERT_SAME(a_never_consumed, clk, rst_n, out_valid, !char_consumed, "ending char consumed")
    `SIP_ASSERT_SAME(a_err_zero, clk, rst_n, out_valid && status, value == '0, "range error value not zero")
    `SIP_ASSERT_SAME(a_busy_before_result, clk, rst_n, $rose(out_valid), $past(!in_ready), "result without busy cycle")
    `SIP_ASSERT_NEXT(a_result_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(value) && $stable(status), "stalled result changed")

endmodule

bind stream_integer_parser_core sip_checker u_sip_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (chars.valid),
    .in_ready      (chars.ready),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .value         (result.value),
    .status        (result.status),
    .char_consumed (result.char_consumed)
);

@@ bench/sip_number_check.sv @@
// ============================================================================
// sip_number_check : parse result checker
// Watches the character, result and config ports, predicts the number each
// request stream ends, and compares every result with the oldest prediction.
// ============================================================================
module sip_number_check
    import sip_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    sip_char_if                  chars,
    sip_result_if                result,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RADIX_W-1:0]   cfg_wdata,
    output int                   fail_count,
    output int                   pending
);

    localparam logic [VALUE_OUT_W-1:0] VALUE_MASK =
        {VALUE_OUT_W{1'b1}} >> (VALUE_OUT_W - VALUE_WIDTH);
    localparam logic [VALUE_OUT_W-1:0] SIGN_BIT = VALUE_OUT_W'(1) << (VALUE_WIDTH - 1);
    localparam logic [CH_W-1:0] CH_A_LO = 8'h61;
    localparam logic [CH_W-1:0] CH_A_UP = 8'h41;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [VALUE_OUT_W-1:0] value;
        logic                   status;
        logic                   char_consumed;
    } number_t;

    number_t                expected_numbers[$];
    logic [RADIX_W-1:0]     cfg_radix;
    logic                   cfg_signed;
    phase_t                 num_phase;
    logic [VALUE_OUT_W-1:0] accum;
    logic [RADIX_W-1:0]     num_base;
    logic                   is_negative;
    int                     reported;
    logic                   ended;
    number_t                predicted;
    number_t                got;
    number_t                want;

    // digit value of a character, all ones for a non-digit
    function automatic logic [RADIX_W-1:0] char_digit(input logic [CH_W-1:0] c);
        logic [RADIX_W-1:0] d;
        d = '1;
        if (c >= CH_ZERO && c <= CH_ZERO + 8'd9)
        begin
            d = RADIX_W'(c - CH_ZERO);
        end
        else if (c >= CH_A_LO && c < CH_A_LO + 8'd6)
        begin
            d = RADIX_W'(c - CH_A_LO + 8'd10);
        end
        else if (c >= CH_A_UP && c < CH_A_UP + 8'd6)
        begin
            d = RADIX_W'(c - CH_A_UP + 8'd10);
        end
        return d;
    endfunction

    task automatic close_number(input logic range_err, output number_t r);
        logic [VALUE_OUT_W-1:0] v;
        logic                   err;
        v   = accum & VALUE_MASK;
        err = range_err;
        if (!err && cfg_signed)
        begin
            if (is_negative)
            begin
                if (v > SIGN_BIT)
                begin
                    err = 1'b1;
                end
                else
                begin
                    v = (-v) & VALUE_MASK;
                end
            end
            else if (v >= SIGN_BIT)
            begin
                err = 1'b1;
            end
        end
        r.value         = err ? '0 : v;
        r.status        = err;
        r.char_consumed = 1'b0;
        num_phase   = PH_SIGN;
        accum       = '0;
        num_base    = '0;
        is_negative = 1'b0;
    endtask

    task automatic take_digit(input logic [CH_W-1:0] c, input logic eoi,
                              output logic done, output number_t r);
        logic [RADIX_W-1:0]         d;
        logic [VALUE_OUT_W+RADIX_W:0] grown;
        done = 1'b1;
        r    = '0;
        d    = char_digit(c);
        if (eoi || d >= num_base)
        begin
            close_number(1'b0, r);
        end
        else
        begin
            grown = accum * num_base + d;
            if (grown > VALUE_MASK)
            begin
                close_number(1'b1, r);
            end
            else
            begin
                accum = grown[VALUE_OUT_W-1:0];
                done  = 1'b0;
            end
        end
    endtask

    task automatic parse_char(input logic [CH_W-1:0] c, input logic eoi,
                              output logic done, output number_t r);
        done = 1'b0;
        r    = '0;
        if (num_phase == PH_SIGN)
        begin
            num_phase = PH_PREFIX;
            if (cfg_signed && !eoi && (c == CH_MINUS || c == CH_PLUS))
            begin
                is_negative = (c == CH_MINUS);
                return;
            end
        end
        if (num_phase == PH_PREFIX)
        begin
            if (eoi)
            begin
                close_number(1'b0, r);
                done = 1'b1;
                return;
            end
            num_phase = PH_DIGITS;
            if (cfg_radix == RADIX_AUTO)
            begin
                num_base = (c == CH_ZERO) ? BASE_OCT : BASE_DEC;
                if (c == CH_ZERO)
                begin
                    num_phase = PH_AFTER_ZERO;
                    return;
                end
            end
            else if (cfg_radix == BASE_HEX)
            begin
                num_base = BASE_HEX;
                if (c == CH_ZERO)
                begin
                    num_phase = PH_AFTER_ZERO;
                    return;
                end
            end
            else
            begin
                num_base = cfg_radix;
            end
        end
        else if (num_phase == PH_AFTER_ZERO)
        begin
            num_phase = PH_DIGITS;
            if (!eoi && (c == CH_X_LO || c == CH_X_UP))
            begin
                num_base = BASE_HEX;
                return;
            end
        end
        take_digit(c, eoi, done, r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_radix   = BASE_DEC;
            cfg_signed  = 1'b0;
            num_phase   = PH_SIGN;
            accum       = '0;
            num_base    = '0;
            is_negative = 1'b0;
            expected_numbers.delete();
            fail_count  = 0;
            pending     = 0;
            reported    = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == CFG_RADIX)
                begin
                    cfg_radix = cfg_wdata;
                end
                else if (cfg_index == CFG_SIGNED_MODE)
                begin
                    cfg_signed = cfg_wdata[0];
                end
            end
            if (chars.valid && chars.ready)
            begin
                parse_char(chars.ch, chars.end_of_input, ended, predicted);
                if (ended)
                begin
                    expected_numbers.push_back(predicted);
                end
            end
            if (result.valid && result.ready)
            begin
                got.value         = result.value;
                got.status        = result.status;
                got.char_consumed = result.char_consumed;
                if (expected_numbers.size() == 0)
                begin
                    fail_count++;
                    if (reported < REPORT_LIMIT)
                    begin
                        $display("unexpected result: value %h status %0d consumed %0d",
                                 got.value, got.status, got.char_consumed);
                    end
                    reported++;
                end
                else
                begin
                    want = expected_numbers.pop_front();
                    if (got.value !== want.value || got.status !== want.status ||
                        got.char_consumed !== want.char_consumed)
                    begin
                        fail_count++;
                        if (reported < REPORT_LIMIT)
                        begin
                            $display("mismatch: value exp %h got %h, status exp %0d got %0d, consumed exp %0d got %0d",
                                     want.value, got.value, want.status, got.status,
                                     want.char_consumed, got.char_consumed);
                        end
                        reported++;
                    end
                end
            end
            pending = expected_numbers.size();
        end
    end

endmodule

@@ bench/tb.sv @@
// ============================================================================
// tb : stream integer parser testbench
// Feeds directed and random character streams in bursts under a stalling
// result receiver, across radix and sign settings; a checker predicts.
// ============================================================================
module tb;
    import sip_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 11;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1100;
    localparam int DRAIN_CYCLES = 16;

    localparam logic [RADIX_W-1:0] RADIX_UNARY = 5'd1;
    localparam logic [RADIX_W-1:0] RADIX_BIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_TOP   = 5'd31;

    localparam logic [CH_W-1:0] CH_A_LO = 8'h61;
    localparam logic [CH_W-1:0] CH_A_UP = 8'h41;
    localparam logic [CH_W-1:0] CH_G_LO = 8'h67;
    localparam logic [CH_W-1:0] STOP_CHARS [8] =
        '{8'h20, 8'h2C, 8'h67, 8'h78, 8'h5A, 8'h2B, 8'h2D, 8'h0A};

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            end_of_input;
    } char_req_t;

    logic                 clk   = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [RADIX_W-1:0]   cfg_wdata;
    int                   fail_count;
    int                   pending;
    int                   cycle_count = 0;
    int                   items_sent  = 0;
    int                   burst_left  = 0;
    bit                   tx_free     = 1'b0;
    bit                   rx_free     = 1'b0;
    char_req_t            text_q[$];

    sip_char_if   chars_if ();
    sip_result_if result_if ();

    stream_integer_parser_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .chars     (chars_if),
        .result    (result_if),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    sip_number_check number_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars_if),
        .result     (result_if),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // result receiver: random runs of ready and stall
    initial
    begin
        int   run_left;
        logic level;
        run_left = 0;
        level    = 1'b1;
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (run_left == 0)
            begin
                level    = ($urandom_range(0, 2) != 0);
                run_left = $urandom_range(1, 10);
            end
            run_left--;
            result_if.ready = rx_free ? 1'b1 : level;
        end
    end

    task automatic put_char(input logic [CH_W-1:0] c);
        text_q.push_back('{ch: c, end_of_input: 1'b0});
    endtask

    task automatic put_end();
        text_q.push_back('{ch: CH_W'($urandom_range(0, 255)), end_of_input: 1'b1});
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            put_char(s[i]);
        end
    endtask

    function automatic logic [CH_W-1:0] digit_char(input int d);
        if (d < 10)
        begin
            return CH_ZERO + CH_W'(d);
        end
        return ($urandom_range(0, 1) ? CH_A_UP : CH_A_LO) + CH_W'(d - 10);
    endfunction

    task automatic put_value(input logic [VALUE_OUT_W-1:0] v, input int b);
        logic [VALUE_OUT_W-1:0] rest;
        logic [CH_W-1:0]        rev[$];
        rest = v;
        do
        begin
            rev.push_back(digit_char(int'(rest % b)));
            rest = rest / b;
        end
        while (rest != 0);
        for (int i = rev.size() - 1; i >= 0; i--)
        begin
            put_char(rev[i]);
        end
    endtask

    function automatic logic [CH_W-1:0] stop_char(input int b);
        case ($urandom_range(0, 3))
            0: return STOP_CHARS[$urandom_range(0, 7)];
            1: return CH_W'($urandom_range(128, 255));
            2: return (b <= 15) ? digit_char(b) : CH_G_LO;
            default: return CH_W'($urandom_range(0, 255));
        endcase
    endfunction

    // one number: mostly well formed, some boundary values, some noise
    task automatic gen_number(input logic [RADIX_W-1:0] r, input logic s);
        int                     b;
        int                     maxd;
        int                     len;
        int                     pick;
        bit                     nonzero_lead;
        logic [VALUE_OUT_W-1:0] bound_v;
        pick         = $urandom_range(0, 99);
        nonzero_lead = 1'b0;
        if (pick < 15)
        begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    put_end();
                end
                else
                begin
                    put_char(CH_W'($urandom_range(0, 255)));
                end
            end
            return;
        end
        if (s ? ($urandom_range(0, 9) < 6) : ($urandom_range(0, 19) == 0))
        begin
            put_char($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
        end
        if (r == RADIX_AUTO)
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    put_char(CH_ZERO);
                    put_char($urandom_range(0, 1) ? CH_X_UP : CH_X_LO);
                    b = 16;
                end
                1:
                begin
                    put_char(CH_ZERO);
                    b = 8;
                end
                default:
                begin
                    b = 10;
                    nonzero_lead = 1'b1;
                end
            endcase
        end
        else
        begin
            b = int'(r);
            if (r == BASE_HEX && $urandom_range(0, 1))
            begin
                put_char(CH_ZERO);
                put_char($urandom_range(0, 1) ? CH_X_UP : CH_X_LO);
            end
        end
        maxd = (b > 16) ? 15 : b - 1;
        if (pick < 35 && b >= 2 && b <= 16)
        begin
            case ($urandom_range(0, 5))
                0: bound_v = '0;
                1: bound_v = 64'h7FFF_FFFF_FFFF_FFFF;
                2: bound_v = 64'h8000_0000_0000_0000;
                3: bound_v = 64'h8000_0000_0000_0001;
                4: bound_v = '1;
                default: bound_v = {$urandom, $urandom};
            endcase
            put_value(bound_v, b);
            if ($urandom_range(0, 2) == 0)
            begin
                put_char(digit_char($urandom_range(0, maxd)));
            end
        end
        else
        begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 24) : $urandom_range(0, 8);
            for (int i = 0; i < len; i++)
            begin
                if (i == 0 && nonzero_lead)
                begin
                    put_char(digit_char($urandom_range(1, 9)));
                end
                else
                begin
                    put_char(digit_char(($urandom_range(0, 2) == 0) ? maxd
                                                                   : $urandom_range(0, maxd)));
                end
            end
        end
        if ($urandom_range(0, 9) < 3)
        begin
            put_end();
        end
        else
        begin
            put_char(stop_char(b));
        end
    endtask

    // drives queued requests in bursts; starts and ends at a falling edge
    task automatic send_text();
        char_req_t req;
        int        gap;
        while (text_q.size() > 0)
        begin
            req = text_q.pop_front();
            if (burst_left == 0)
            begin
                gap = tx_free ? 0 : $urandom_range(0, 8);
                if (gap > 0)
                begin
                    chars_if.valid = 1'b0;
                    repeat (gap) @(negedge clk);
                end
                burst_left = $urandom_range(1, 12);
            end
            chars_if.valid        = 1'b1;
            chars_if.ch           = req.ch;
            chars_if.end_of_input = req.end_of_input;
            @(posedge clk);
            while (!chars_if.ready)
            begin
                @(posedge clk);
            end
            @(negedge clk);
            burst_left--;
            items_sent++;
        end
        chars_if.valid = 1'b0;
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [RADIX_W-1:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic wait_idle();
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int                 phase_no;
        int                 budget;
        logic [RADIX_W-1:0] r;
        logic               s;
        chars_if.valid        = 1'b0;
        chars_if.ch           = '0;
        chars_if.end_of_input = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_index             = CFG_RADIX;
        cfg_wdata             = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // reset settings: decimal, unsigned
        put_end();
        put_str("+");
        put_char(8'hFF);
        put_str("98;");
        send_text();

        wait_idle();
        write_cfg(CFG_RADIX, BASE_HEX);
        put_str("0x");
        put_end();
        put_str("0f");
        put_end();
        put_str("0XAz");
        send_text();

        wait_idle();
        write_cfg(CFG_RADIX, RADIX_AUTO);
        write_cfg(CFG_SIGNED_MODE, '1);
        put_str("-078");
        put_str("+0xF");
        put_end();
        put_str("-");
        put_end();
        send_text();

        wait_idle();
        write_cfg(CFG_RADIX, RADIX_UNARY);
        put_str("01");
        send_text();

        wait_idle();
        write_cfg(CFG_RADIX, RADIX_TOP);
        put_str("f");
        put_end();
        send_text();

        items_sent = 0;
        phase_no   = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            case (phase_no)
                0: begin r = RADIX_AUTO; s = 1'b1; end
                1: begin r = BASE_HEX;   s = 1'b0; end
                2: begin r = BASE_DEC;   s = 1'b1; end
                3: begin r = RADIX_BIN;  s = 1'b0; end
                default:
                begin
                    s = $urandom_range(0, 1);
                    case ($urandom_range(0, 9))
                        0: r = RADIX_AUTO;
                        1: r = BASE_HEX;
                        2: r = BASE_DEC;
                        3: r = BASE_OCT;
                        4: r = RADIX_UNARY;
                        5: r = RADIX_BIN;
                        6: r = RADIX_W'($urandom_range(17, 31));
                        default: r = RADIX_W'($urandom_range(2, 16));
                    endcase
                end
            endcase
            wait_idle();
            write_cfg(CFG_RADIX, r);
            write_cfg(CFG_SIGNED_MODE, {4'($urandom_range(0, 15)), s});
            tx_free = (phase_no % 4 == 3);
            rx_free = (phase_no % 5 == 2);
            budget  = $urandom_range(80, 160);
            while (text_q.size() < budget)
            begin
                gen_number(r, s);
            end
            put_end();
            send_text();
            phase_no++;
        end

        wait_idle();
        if (fail_count == 0 && pending == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
